/* rtl/abom_pkg.sv */
`timescale 1ns / 1ps

package abom_pkg;

   // Grid geometry
   localparam int MAX_GRID_W  = 512;
   localparam int MAX_GRID_H  = 512;
   localparam int TABLE_DEPTH = MAX_GRID_W * MAX_GRID_H;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CELL_X_W    = $clog2(MAX_GRID_W);
   localparam int CELL_Y_W    = $clog2(MAX_GRID_H);

   // Field widths
   localparam int FUNC_W     = 1;
   localparam int COL_W      = 9;
   localparam int ROW_W      = 9;
   localparam int SUM_W      = 19;
   localparam int COORD_W    = 20;
   localparam int RADIUS_W   = 19;
   localparam int CPU_W      = 24;
   localparam int FRAC_W     = 24;
   localparam int GRID_REG_W = 10;
   localparam int COUNT_W    = 21;

   // Datapath widths
   localparam int DIFF_W     = 22;
   localparam int MAG_W      = DIFF_W - 1;
   localparam int MUL_W      = MAG_W + CPU_W;
   localparam int CELL_RAW_W = MUL_W - FRAC_W;
   localparam int CMP_W      = 24;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CPU_W-1:0]      CPU_RESET  = CPU_W'(65536);
   localparam logic [GRID_REG_W-1:0] GRID_RESET = GRID_REG_W'(512);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD  = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RANGE_MIN_X    = 3'd0,
      CSR_RANGE_MIN_Y    = 3'd1,
      CSR_CELLS_PER_UNIT_X = 3'd2,
      CSR_CELLS_PER_UNIT_Y = 3'd3,
      CSR_GRID_WIDTH     = 3'd4,
      CSR_GRID_HEIGHT    = 3'd5
   } csr_index_type;

   // Saturate the grid size into [1, maxv] and clamp a raw cell into [0, limit - 1]
   function automatic logic [CMP_W-1:0] clamp_cell(input logic [CELL_RAW_W-1:0] raw,
                                                   input logic [GRID_REG_W-1:0] grid,
                                                   input int maxv);
      logic [CMP_W-1:0] lim;
      logic [CMP_W-1:0] pos;
      lim = CMP_W'(grid);
      pos = CMP_W'(raw);
      if (lim == '0) begin
         lim = CMP_W'(1);
      end else if (lim > CMP_W'(maxv)) begin
         lim = CMP_W'(maxv);
      end
      if (pos > lim - CMP_W'(1)) begin
         pos = lim - CMP_W'(1);
      end
      return pos;
   endfunction

   // Row major table address with a stride of MAX_GRID_W
   function automatic logic [ADDR_W-1:0] addr_of(input logic [ADDR_W-1:0] row,
                                                 input logic [ADDR_W-1:0] col);
      return ADDR_W'(row * ADDR_W'(MAX_GRID_W) + col);
   endfunction

endpackage

/* rtl/abom_ram.sv */
`timescale 1ns / 1ps

module abom_ram #(
   parameter int WIDTH = 19,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port; read data holds until the next read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/anchor_box_occupancy_mask_unit.sv */
// A query passes stages 1 to 3, four table reads and the SUM state before rsp_valid.
// Load throughput: one entry per cycle while the sequencer is free. A query holds
// the single-ported summed-area memory for its four reads, one read a cycle.
// Reset (synchronous, active high) empties the pipeline and the result register and
// restores the configuration registers; the table memory is not cleared and an entry
// is undefined until loaded.
`timescale 1ns / 1ps

module anchor_box_occupancy_mask_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [abom_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [abom_pkg::CSR_DATA_W-1:0]      csr_data,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [abom_pkg::FUNC_W-1:0]          req_func,
   input  logic [abom_pkg::COL_W-1:0]           req_entry_col,
   input  logic [abom_pkg::ROW_W-1:0]           req_entry_row,
   input  logic [abom_pkg::SUM_W-1:0]           req_entry_sum,
   input  logic signed [abom_pkg::COORD_W-1:0]  req_anchor_x,
   input  logic signed [abom_pkg::COORD_W-1:0]  req_anchor_y,
   input  logic [abom_pkg::RADIUS_W-1:0]        req_anchor_radius,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_anchor_hit,
   output logic signed [abom_pkg::COUNT_W-1:0]  rsp_window_count
);

   import abom_pkg::*;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic signed [COORD_W-1:0] range_min_x_ff;
   logic signed [COORD_W-1:0] range_min_y_ff;
   logic [CPU_W-1:0]          cpu_x_ff;
   logic [CPU_W-1:0]          cpu_y_ff;
   logic [GRID_REG_W-1:0]     grid_width_ff;
   logic [GRID_REG_W-1:0]     grid_height_ff;

   // Writes must come only while idle; unchecked, the block always takes them
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_x_ff <= '0;
         range_min_y_ff <= '0;
         cpu_x_ff       <= CPU_RESET;
         cpu_y_ff       <= CPU_RESET;
         grid_width_ff  <= GRID_RESET;
         grid_height_ff <= GRID_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RANGE_MIN_X:      range_min_x_ff <= signed'(csr_data[COORD_W-1:0]);
            CSR_RANGE_MIN_Y:      range_min_y_ff <= signed'(csr_data[COORD_W-1:0]);
            CSR_CELLS_PER_UNIT_X: cpu_x_ff       <= csr_data[CPU_W-1:0];
            CSR_CELLS_PER_UNIT_Y: cpu_y_ff       <= csr_data[CPU_W-1:0];
            CSR_GRID_WIDTH:       grid_width_ff  <= csr_data[GRID_REG_W-1:0];
            CSR_GRID_HEIGHT:      grid_height_ff <= csr_data[GRID_REG_W-1:0];
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Front end: three stages turn the anchor into clamped corner cells.
   // Loads ride along so that table writes stay in transfer order.
   //   stage 1: corner offsets, centre -/+ radius - range minimum
   //   stage 2: offsets times cells per unit (zero for offsets <= 0)
   //   stage 3: drop the fraction and clamp into the grid
   // ------------------------------------------------------------------
   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                     s1_ready, s2_ready, s3_ready;
   logic [FUNC_W-1:0]        s1_func_ff, s2_func_ff, s3_func_ff;
   logic [COL_W-1:0]         s1_col_ff, s2_col_ff, s3_col_ff;
   logic [ROW_W-1:0]         s1_row_ff, s2_row_ff, s3_row_ff;
   logic [SUM_W-1:0]         s1_sum_ff, s2_sum_ff, s3_sum_ff;

   logic signed [DIFF_W-1:0] dx0_in, dx1_in, dy0_in, dy1_in;
   logic signed [DIFF_W-1:0] dx0_ff, dx1_ff, dy0_ff, dy1_ff;
   logic [MUL_W-1:0]         px0_in, px1_in, py0_in, py1_in;
   logic [MUL_W-1:0]         px0_ff, px1_ff, py0_ff, py1_ff;
   logic [CELL_X_W-1:0]      x0_in, x1_in, x0_ff, x1_ff;
   logic [CELL_Y_W-1:0]      y0_in, y1_in, y0_ff, y1_ff;

   logic seq_take;  // sequencer takes the stage 3 item this cycle

   assign s3_ready  = !s3_valid_ff || seq_take;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_comb begin
      logic signed [DIFF_W-1:0] ax, ay, rad;
      ax  = DIFF_W'(req_anchor_x);
      ay  = DIFF_W'(req_anchor_y);
      rad = DIFF_W'(signed'({1'b0, req_anchor_radius}));
      dx0_in = ax - rad - DIFF_W'(range_min_x_ff);
      dx1_in = ax + rad - DIFF_W'(range_min_x_ff);
      dy0_in = ay - rad - DIFF_W'(range_min_y_ff);
      dy1_in = ay + rad - DIFF_W'(range_min_y_ff);
   end

   // Offsets at or below zero map to cell 0
   function automatic logic [MUL_W-1:0] scale(input logic signed [DIFF_W-1:0] d,
                                              input logic [CPU_W-1:0] cpu);
      logic [MUL_W-1:0] p;
      p = '0;
      if (!d[DIFF_W-1] && d != '0) begin
         p = MUL_W'(d[MAG_W-1:0]) * MUL_W'(cpu);
      end
      return p;
   endfunction

   assign px0_in = scale(dx0_ff, cpu_x_ff);
   assign px1_in = scale(dx1_ff, cpu_x_ff);
   assign py0_in = scale(dy0_ff, cpu_y_ff);
   assign py1_in = scale(dy1_ff, cpu_y_ff);

   assign x0_in = CELL_X_W'(clamp_cell(px0_ff[MUL_W-1:FRAC_W], grid_width_ff, MAX_GRID_W));
   assign x1_in = CELL_X_W'(clamp_cell(px1_ff[MUL_W-1:FRAC_W], grid_width_ff, MAX_GRID_W));
   assign y0_in = CELL_Y_W'(clamp_cell(py0_ff[MUL_W-1:FRAC_W], grid_height_ff, MAX_GRID_H));
   assign y1_in = CELL_Y_W'(clamp_cell(py1_ff[MUL_W-1:FRAC_W], grid_height_ff, MAX_GRID_H));

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage payloads; advance together with the valid bits
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_func_ff <= req_func;
         s1_col_ff  <= req_entry_col;
         s1_row_ff  <= req_entry_row;
         s1_sum_ff  <= req_entry_sum;
         dx0_ff     <= dx0_in;
         dx1_ff     <= dx1_in;
         dy0_ff     <= dy0_in;
         dy1_ff     <= dy1_in;
      end
      if (s2_ready) begin
         s2_func_ff <= s1_func_ff;
         s2_col_ff  <= s1_col_ff;
         s2_row_ff  <= s1_row_ff;
         s2_sum_ff  <= s1_sum_ff;
         px0_ff     <= px0_in;
         px1_ff     <= px1_in;
         py0_ff     <= py0_in;
         py1_ff     <= py1_in;
      end
      if (s3_ready) begin
         s3_func_ff <= s2_func_ff;
         s3_col_ff  <= s2_col_ff;
         s3_row_ff  <= s2_row_ff;
         s3_sum_ff  <= s2_sum_ff;
         x0_ff      <= x0_in;
         x1_ff      <= x1_in;
         y0_ff      <= y0_in;
         y1_ff      <= y1_in;
      end
   end

   // ------------------------------------------------------------------
   // Memory sequencer. A query reads BR at take, then TR, BL and TL in
   // RD_TR, RD_BL and RD_TL; each read's data lands the next cycle and is
   // folded into the running sum. The SUM state folds TL into the result
   // register, and in that same cycle the next item may be taken, since
   // SUM issues no read. A load writes the table in the cycle it is taken.
   // All accesses go through one port in transfer order, so a read after
   // a write of the same entry always sees the new value.
   // ------------------------------------------------------------------
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_RD_TR,
      SEQ_RD_BL,
      SEQ_RD_TL,
      SEQ_SUM
   } seq_state_type;

   seq_state_type              state_ff;
   logic [CELL_X_W-1:0]        qx0_ff, qx1_ff;
   logic [CELL_Y_W-1:0]        qy0_ff, qy1_ff;
   logic signed [COUNT_W-1:0]  acc_ff;
   logic signed [COUNT_W-1:0]  area;
   logic                       rsp_valid_ff;
   logic                       rsp_hit_ff;
   logic signed [COUNT_W-1:0]  rsp_count_ff;
   logic                       out_free;
   logic                       seq_free;
   logic                       take_query;
   logic                       load_hit;

   logic                       ram_en;
   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_addr;
   logic [SUM_W-1:0]           ram_rdata;
   logic signed [COUNT_W-1:0]  rd_val;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign seq_free   = (state_ff == SEQ_IDLE) || ((state_ff == SEQ_SUM) && out_free);
   assign seq_take   = s3_valid_ff && seq_free;
   assign take_query = seq_take && (s3_func_ff == FUNC_QUERY);

   // Drop loads outside the table
   assign load_hit = (CMP_W'(s3_col_ff) < CMP_W'(MAX_GRID_W))
                  && (CMP_W'(s3_row_ff) < CMP_W'(MAX_GRID_H));
   assign ram_we   = seq_take && (s3_func_ff == FUNC_LOAD) && load_hit;

   always_comb begin
      ram_en   = 1'b0;
      ram_addr = '0;
      if (ram_we) begin
         ram_en   = 1'b1;
         ram_addr = addr_of(ADDR_W'(s3_row_ff), ADDR_W'(s3_col_ff));
      end else if (take_query) begin
         ram_en   = 1'b1;
         ram_addr = addr_of(ADDR_W'(y1_ff), ADDR_W'(x1_ff));
      end else begin
         case (state_ff)
            SEQ_RD_TR: begin
               ram_en   = 1'b1;
               ram_addr = addr_of(ADDR_W'(qy0_ff), ADDR_W'(qx1_ff));
            end
            SEQ_RD_BL: begin
               ram_en   = 1'b1;
               ram_addr = addr_of(ADDR_W'(qy1_ff), ADDR_W'(qx0_ff));
            end
            SEQ_RD_TL: begin
               ram_en   = 1'b1;
               ram_addr = addr_of(ADDR_W'(qy0_ff), ADDR_W'(qx0_ff));
            end
            default: ;
         endcase
      end
   end

   abom_ram #(
      .WIDTH (SUM_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (s3_sum_ff),
      .rdata (ram_rdata)
   );

   assign rd_val = signed'(COUNT_W'(ram_rdata));
   assign area   = acc_ff + rd_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a finished sum, else retire the result register when taken
         if (state_ff == SEQ_SUM && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            SEQ_IDLE, SEQ_SUM: begin
               if (state_ff == SEQ_SUM && out_free) begin
                  rsp_count_ff <= area;
                  rsp_hit_ff   <= !area[COUNT_W-1] && (area != '0);
               end
               if (seq_free) begin
                  state_ff <= take_query ? SEQ_RD_TR : SEQ_IDLE;
               end
               if (take_query) begin
                  qx0_ff <= x0_ff;
                  qx1_ff <= x1_ff;
                  qy0_ff <= y0_ff;
                  qy1_ff <= y1_ff;
               end
            end
            SEQ_RD_TR: begin
               acc_ff   <= rd_val;            // BR
               state_ff <= SEQ_RD_BL;
            end
            SEQ_RD_BL: begin
               acc_ff   <= acc_ff - rd_val;   // minus TR
               state_ff <= SEQ_RD_TL;
            end
            SEQ_RD_TL: begin
               acc_ff   <= acc_ff - rd_val;   // minus BL
               state_ff <= SEQ_SUM;
            end
            default: state_ff <= SEQ_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_anchor_hit   = rsp_hit_ff;
   assign rsp_window_count = rsp_count_ff;

endmodule

/* rtl/abom_checker.sv */
`timescale 1ns / 1ps

module abom_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [abom_pkg::FUNC_W-1:0]          req_func,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_anchor_hit,
   input logic signed [abom_pkg::COUNT_W-1:0]  rsp_window_count
);

   import abom_pkg::*;

   // Queries taken but whose results are not yet transferred
   logic [3:0] open_ff;
   logic       q_in;
   logic       r_out;

   assign q_in  = req_valid && req_ready && (req_func == FUNC_QUERY);
   assign r_out = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_ff + 4'(q_in) - 4'(r_out);
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != '0)
      else $error("result without an open query");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      open_ff <= 4'd5)
      else $error("more open queries than pipeline slots");

   a_hit_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_anchor_hit
                    == (!rsp_window_count[COUNT_W-1] && rsp_window_count != '0))
      else $error("hit flag disagrees with window count");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_window_count))
      else $error("stalled result changed");

endmodule

bind anchor_box_occupancy_mask_unit abom_checker u_abom_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_func         (req_func),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_anchor_hit   (rsp_anchor_hit),
   .rsp_window_count (rsp_window_count)
);

/* dv/occupancy_check_pkg.sv */
`timescale 1ns / 1ps

package occupancy_check_pkg;
   import abom_pkg::*;

   typedef struct {
      func_type                  func;
      logic [COL_W-1:0]          entry_col;
      logic [ROW_W-1:0]          entry_row;
      logic [SUM_W-1:0]          entry_sum;
      logic signed [COORD_W-1:0] anchor_x;
      logic signed [COORD_W-1:0] anchor_y;
      logic [RADIUS_W-1:0]       anchor_radius;
   } request_item;

   typedef struct {
      logic                      hit;
      logic signed [COUNT_W-1:0] count;
   } window_result;

   // Mirror of the summed-area table and the mapping registers; holds the
   // window counts still owed by the block, oldest first.
   class window_count_tracker;
      logic [SUM_W-1:0]          prefix_sums [TABLE_DEPTH];
      bit                        loaded [TABLE_DEPTH];
      logic signed [COORD_W-1:0] x_origin;
      logic signed [COORD_W-1:0] y_origin;
      logic [CPU_W-1:0]          x_scale;
      logic [CPU_W-1:0]          y_scale;
      logic [GRID_REG_W-1:0]     cols_in_use;
      logic [GRID_REG_W-1:0]     rows_in_use;
      window_result              owed_counts [$];
      int                        errors;

      function void reset_config();
         x_origin    = '0;
         y_origin    = '0;
         x_scale     = CPU_RESET;
         y_scale     = CPU_RESET;
         cols_in_use = GRID_RESET;
         rows_in_use = GRID_RESET;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_RANGE_MIN_X:      x_origin    = data[COORD_W-1:0];
            CSR_RANGE_MIN_Y:      y_origin    = data[COORD_W-1:0];
            CSR_CELLS_PER_UNIT_X: x_scale     = data[CPU_W-1:0];
            CSR_CELLS_PER_UNIT_Y: y_scale     = data[CPU_W-1:0];
            CSR_GRID_WIDTH:       cols_in_use = data[GRID_REG_W-1:0];
            CSR_GRID_HEIGHT:      rows_in_use = data[GRID_REG_W-1:0];
            default: ;
         endcase
      endfunction

      // Zero acts as one, anything past the table acts as the table size.
      function int usable_extent(logic [GRID_REG_W-1:0] size, int maxv);
         if (size == '0) return 1;
         if (int'(size) > maxv) return maxv;
         return int'(size);
      endfunction

      function int scale_to_cell(longint offset, logic [CPU_W-1:0] scale, int extent);
         longint grid_pos;
         if (offset <= 0) return 0;
         grid_pos = (offset * longint'(scale)) >>> FRAC_W;
         if (grid_pos > longint'(extent - 1)) return extent - 1;
         return int'(grid_pos);
      endfunction

      function void window_cells(input logic signed [COORD_W-1:0] ax,
                                 input logic signed [COORD_W-1:0] ay,
                                 input logic [RADIUS_W-1:0] rad,
                                 output int x0, output int x1,
                                 output int y0, output int y1);
         int cols;
         int rows;
         cols = usable_extent(cols_in_use, MAX_GRID_W);
         rows = usable_extent(rows_in_use, MAX_GRID_H);
         x0 = scale_to_cell(longint'(ax) - longint'(rad) - longint'(x_origin), x_scale, cols);
         x1 = scale_to_cell(longint'(ax) + longint'(rad) - longint'(x_origin), x_scale, cols);
         y0 = scale_to_cell(longint'(ay) - longint'(rad) - longint'(y_origin), y_scale, rows);
         y1 = scale_to_cell(longint'(ay) + longint'(rad) - longint'(y_origin), y_scale, rows);
      endfunction

      function void note_request(request_item item);
         int x0, x1, y0, y1;
         int slot;
         longint area;
         window_result owed;
         if (item.func == FUNC_LOAD) begin
            slot = int'(item.entry_row) * MAX_GRID_W + int'(item.entry_col);
            prefix_sums[slot] = item.entry_sum;
            loaded[slot]      = 1'b1;
            return;
         end
         window_cells(item.anchor_x, item.anchor_y, item.anchor_radius, x0, x1, y0, y1);
         area = longint'(prefix_sums[y1 * MAX_GRID_W + x1])
              - longint'(prefix_sums[y0 * MAX_GRID_W + x1])
              - longint'(prefix_sums[y1 * MAX_GRID_W + x0])
              + longint'(prefix_sums[y0 * MAX_GRID_W + x0]);
         owed.hit   = (area >= 1);
         owed.count = COUNT_W'(area);
         owed_counts.push_back(owed);
      endfunction

      function void check_response(logic hit, logic signed [COUNT_W-1:0] count);
         window_result owed;
         if (owed_counts.size() == 0) begin
            $error("window result with none outstanding: anchor_hit %0d window_count %0d",
                   hit, count);
            errors++;
            return;
         end
         owed = owed_counts.pop_front();
         if (hit !== owed.hit) begin
            $error("anchor_hit mismatch: expected %0d, actual %0d", owed.hit, hit);
            errors++;
         end
         if (count !== owed.count) begin
            $error("window_count mismatch: expected %0d, actual %0d", owed.count, count);
            errors++;
         end
      endfunction

      function int pending();
         return owed_counts.size();
      endfunction
   endclass

endpackage

/* dv/tb_anchor_box_occupancy_mask_unit.sv */
`timescale 1ns / 1ps

module tb_anchor_box_occupancy_mask_unit;
   import abom_pkg::*;
   import occupancy_check_pkg::*;

   localparam int ITEM_TARGET    = 1700;
   localparam int PHASE_ITEMS    = 200;
   // Give the pipeline a comfortable margin to empty.
   localparam int DRAIN_CYCLES   = 16;
   localparam int LONG_HOLD      = 300;
   // Longest legal silence is the long receiver hold plus a sender gap and the
   // pipeline latency; allow many times that.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SUM_MAX        = 262144;
   localparam int RADIUS_MAX     = 524287;
   localparam int COORD_MIN      = -524288;
   localparam int COORD_MAX      = 524287;

   // Indexes past the register file; writes there must leave every register alone.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [FUNC_W-1:0]         req_func = '0;
   logic [COL_W-1:0]          req_entry_col = '0;
   logic [ROW_W-1:0]          req_entry_row = '0;
   logic [SUM_W-1:0]          req_entry_sum = '0;
   logic signed [COORD_W-1:0] req_anchor_x = '0;
   logic signed [COORD_W-1:0] req_anchor_y = '0;
   logic [RADIUS_W-1:0]       req_anchor_radius = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_anchor_hit;
   logic signed [COUNT_W-1:0] rsp_window_count;

   window_count_tracker box_checker = new();

   int items_sent   = 0;
   int burst_left   = 0;
   int quiet_cycles = 0;
   bit hold_request = 1'b0;

   anchor_box_occupancy_mask_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_entry_col     (req_entry_col),
      .req_entry_row     (req_entry_row),
      .req_entry_sum     (req_entry_sum),
      .req_anchor_x      (req_anchor_x),
      .req_anchor_y      (req_anchor_y),
      .req_anchor_radius (req_anchor_radius),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_anchor_hit    (rsp_anchor_hit),
      .rsp_window_count  (rsp_window_count)
   );

   always #5 clock = ~clock;

   // Fill every field with noise; callers overwrite the ones that matter so the
   // don't-care fields still toggle.
   function automatic request_item random_request();
      request_item item;
      item.func          = func_type'($urandom_range(0, 1));
      item.entry_col     = COL_W'($urandom);
      item.entry_row     = ROW_W'($urandom);
      item.entry_sum     = SUM_W'($urandom_range(0, SUM_MAX));
      item.anchor_x      = COORD_W'($urandom);
      item.anchor_y      = COORD_W'($urandom);
      item.anchor_radius = RADIUS_W'($urandom);
      return item;
   endfunction

   // Whole (Q.0) coordinate units covered by one grid cell at a given scale, capped to the radius range.
   function automatic int cell_span(logic [CPU_W-1:0] scale);
      longint units;
      if (scale == '0) return RADIUS_MAX;
      units = (longint'(1) <<< FRAC_W) / longint'(scale);
      return (units > RADIUS_MAX) ? RADIUS_MAX : int'(units);
   endfunction

   // Mostly small grids so corners repeat; sometimes zero or past the table.
   function automatic logic [CSR_DATA_W-1:0] random_grid();
      int pick;
      int size;
      pick = $urandom_range(0, 9);
      if (pick == 0) size = 0;
      else if (pick == 1) size = $urandom_range(MAX_GRID_W + 1, 1023);
      else if (pick < 6) size = $urandom_range(1, 16);
      else size = $urandom_range(1, MAX_GRID_W);
      return (CSR_DATA_W'($urandom) << GRID_REG_W) | CSR_DATA_W'(size);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_scale();
      if ($urandom_range(0, 3) == 0) return CSR_DATA_W'($urandom);
      return CSR_DATA_W'($urandom_range(4096, 1 << 20));
   endfunction

   // Offer one request and hold it until the transfer; then either keep the
   // burst going or drop valid for a random gap.
   task automatic send_request(input request_item item);
      int gap;
      req_valid         <= 1'b1;
      req_func          <= item.func;
      req_entry_col     <= item.entry_col;
      req_entry_row     <= item.entry_row;
      req_entry_sum     <= item.entry_sum;
      req_anchor_x      <= item.anchor_x;
      req_anchor_y      <= item.anchor_y;
      req_anchor_radius <= item.anchor_radius;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      box_checker.note_request(item);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_load(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                            input logic [SUM_W-1:0] sum);
      request_item item;
      item           = random_request();
      item.func      = FUNC_LOAD;
      item.entry_col = col;
      item.entry_row = row;
      item.entry_sum = sum;
      send_request(item);
   endtask

   // Load any of the four corner entries not yet written, then send the query,
   // so no read ever touches an entry that was never loaded.
   task automatic issue_query(input logic signed [COORD_W-1:0] ax,
                              input logic signed [COORD_W-1:0] ay,
                              input logic [RADIUS_W-1:0] rad);
      int x0, x1, y0, y1;
      int rows [4];
      int cols [4];
      request_item item;
      box_checker.window_cells(ax, ay, rad, x0, x1, y0, y1);
      rows = '{y1, y0, y1, y0};
      cols = '{x0, x0, x1, x1};
      for (int k = 0; k < 4; k++) begin
         if (!box_checker.loaded[rows[k] * MAX_GRID_W + cols[k]]) begin
            send_load(COL_W'(cols[k]), ROW_W'(rows[k]), SUM_W'($urandom_range(0, SUM_MAX)));
         end
      end
      item               = random_request();
      item.func          = FUNC_QUERY;
      item.anchor_x      = ax;
      item.anchor_y      = ay;
      item.anchor_radius = rad;
      send_request(item);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      box_checker.write_reg(index, data);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] origin_x,
                            input logic [CSR_DATA_W-1:0] origin_y,
                            input logic [CSR_DATA_W-1:0] scale_x,
                            input logic [CSR_DATA_W-1:0] scale_y,
                            input logic [CSR_DATA_W-1:0] cols,
                            input logic [CSR_DATA_W-1:0] rows);
      write_csr(CSR_RANGE_MIN_X, origin_x);
      write_csr(CSR_RANGE_MIN_Y, origin_y);
      write_csr(CSR_CELLS_PER_UNIT_X, scale_x);
      write_csr(CSR_CELLS_PER_UNIT_Y, scale_y);
      write_csr(CSR_GRID_WIDTH, cols);
      write_csr(CSR_GRID_HEIGHT, rows);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, wait for every owed result, then let trailing loads settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (box_checker.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Stimulus: directed corners first, then phases of random traffic, each
   // under its own mapping registers written while the block is idle.
   initial begin : stimulus
      int phase;
      int stop_at;
      int pick;
      int span_x, span_y;
      int cols, rows;
      bit paused;
      logic signed [COORD_W-1:0] ax, ay;
      logic [RADIUS_W-1:0] rad;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      box_checker.reset_config();
      @(posedge clock);

      // Unmapped register indexes: the transfer completes, nothing changes.
      write_csr(CSR_SPARE_LO, CSR_DATA_W'($urandom));
      write_csr(CSR_SPARE_HI, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;

      // Full-grid window with extreme sums at the four corners: most positive count.
      send_load(COL_W'(0), ROW_W'(0), SUM_W'(SUM_MAX));
      send_load(COL_W'(511), ROW_W'(0), SUM_W'(0));
      send_load(COL_W'(0), ROW_W'(511), SUM_W'(0));
      send_load(COL_W'(511), ROW_W'(511), SUM_W'(SUM_MAX));
      issue_query(COORD_W'(65536), COORD_W'(65536), RADIUS_W'(RADIUS_MAX));
      // Swap the corner sums: most negative count.
      send_load(COL_W'(0), ROW_W'(0), SUM_W'(0));
      send_load(COL_W'(511), ROW_W'(0), SUM_W'(SUM_MAX));
      send_load(COL_W'(0), ROW_W'(511), SUM_W'(SUM_MAX));
      send_load(COL_W'(511), ROW_W'(511), SUM_W'(0));
      issue_query(COORD_W'(65536), COORD_W'(65536), RADIUS_W'(RADIUS_MAX));
      // Most negative centre, no radius: every corner lands below the grid.
      issue_query(COORD_W'(COORD_MIN), COORD_W'(COORD_MIN), RADIUS_W'(0));
      // Most positive centre, widest radius: lower corner at zero, upper clamped.
      issue_query(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX), RADIUS_W'(RADIUS_MAX));
      // Zero radius far past the grid: all four reads on the last cell.
      issue_query(COORD_W'(COORD_MAX), COORD_W'(COORD_MAX), RADIUS_W'(0));
      send_load(COL_W'(511), ROW_W'(0), 19'h3FFFF);
      // One-cell window: a count of exactly one sets the hit flag, zero clears it.
      send_load(COL_W'(1), ROW_W'(1), SUM_W'(5));
      send_load(COL_W'(2), ROW_W'(1), SUM_W'(5));
      send_load(COL_W'(1), ROW_W'(2), SUM_W'(5));
      send_load(COL_W'(2), ROW_W'(2), SUM_W'(6));
      issue_query(COORD_W'(384), COORD_W'(384), RADIUS_W'(128));
      send_load(COL_W'(2), ROW_W'(2), SUM_W'(5));
      issue_query(COORD_W'(384), COORD_W'(384), RADIUS_W'(128));

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         case (phase)
            // Extreme registers: zero and oversized grids, zero and full scales.
            0: configure(CSR_DATA_W'(COORD_MIN), CSR_DATA_W'(COORD_MAX),
                         CSR_DATA_W'(24'hFFFFFF), CSR_DATA_W'(0),
                         CSR_DATA_W'(0), CSR_DATA_W'(1023));
            1: configure(CSR_DATA_W'(COORD_MAX), CSR_DATA_W'(COORD_MIN),
                         CSR_DATA_W'(1), CSR_DATA_W'(24'hFFFFFF),
                         CSR_DATA_W'(MAX_GRID_W), CSR_DATA_W'(1));
            2: configure(CSR_DATA_W'(0), CSR_DATA_W'(0),
                         CSR_DATA_W'(CPU_RESET), CSR_DATA_W'(CPU_RESET),
                         CSR_DATA_W'(GRID_RESET), CSR_DATA_W'(GRID_RESET));
            default: configure(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                               random_scale(), random_scale(),
                               random_grid(), random_grid());
         endcase
         // Ask the receiver for its long hold while this phase keeps offering.
         if (phase == 2) hold_request <= 1'b1;

         stop_at = items_sent + PHASE_ITEMS;
         paused  = 1'b0;
         while (items_sent < stop_at) begin
            // Halfway through one phase, hold off until every result is back.
            if (phase == 4 && !paused && items_sent >= stop_at - PHASE_ITEMS / 2) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (box_checker.pending() != 0);
               paused = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
               // Stray load anywhere in the table, possibly over a live corner.
               send_load(COL_W'($urandom), ROW_W'($urandom),
                         SUM_W'($urandom_range(0, SUM_MAX)));
            end else begin
               span_x = cell_span(box_checker.x_scale);
               span_y = cell_span(box_checker.y_scale);
               cols   = box_checker.usable_extent(box_checker.cols_in_use, MAX_GRID_W);
               rows   = box_checker.usable_extent(box_checker.rows_in_use, MAX_GRID_H);
               if (pick < 8) begin
                  // Aim the centre at a random cell so windows land inside the grid.
                  ax = COORD_W'(longint'(box_checker.x_origin)
                       + longint'($urandom_range(0, cols - 1)) * span_x
                       + longint'($urandom_range(0, span_x - 1)));
                  ay = COORD_W'(longint'(box_checker.y_origin)
                       + longint'($urandom_range(0, rows - 1)) * span_y
                       + longint'($urandom_range(0, span_y - 1)));
                  rad = RADIUS_W'($urandom_range(0, 4 * ((span_x < span_y) ? span_x : span_y)));
               end else begin
                  ax  = COORD_W'($urandom);
                  ay  = COORD_W'($urandom);
                  rad = RADIUS_W'($urandom);
               end
               issue_query(ax, ay, rad);
            end
         end
         phase++;
      end

      wait_idle();
      if (box_checker.errors == 0 && box_checker.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Result side: check each transfer, then pick the next ready level. The
   // pattern switches between always ready, coin flips and mostly stalled.
   initial begin : response_side
      int hold_left;
      int pattern_left;
      int mode;
      bit hold_done;
      hold_left    = 0;
      pattern_left = 0;
      mode         = 0;
      hold_done    = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            box_checker.check_response(rsp_anchor_hit, rsp_window_count);
         end
         if (hold_request && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               mode         = $urandom_range(0, 2);
               pattern_left = $urandom_range(8, 64);
            end
            pattern_left--;
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Watchdog: restart the count on any transfer, end the run if it runs out.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("no transfer on any channel for %0d cycles", WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule
